// ----- sv/capture_period_frequency_meter_defines.svh -----
// Assertion macros for the capture period frequency meter checker.
// Included by the checker file only; needs nothing else.
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_DEFINES_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define CPFM_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CPFM_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/cpfm_pkg.sv -----
// Shared types and constants of the capture period frequency meter.
// Used by the front end, back end, top level and checker; depends on nothing.
package cpfm_pkg;

    localparam int MODE_W     = 2;
    localparam int CAP_W      = 16;
    localparam int FREQ_W     = 24;
    localparam int LOST_W     = 16;
    localparam int MOD_W      = 16;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CMD_W      = 2;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

    localparam logic [MOD_W-1:0]  MODULUS_RESET   = 16'hFFFF;
    localparam logic [FREQ_W-1:0] NUMERATOR_RESET = 24'd1562500;
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 8'd5;
    localparam logic [LOST_W-1:0] LOST_MAX        = 16'hFFFF;

    // Commands passed from the front end to the back end.
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PERIOD = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CAP_W-1:0]  capture_value;
    } sample_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              freq_stable;
        logic              meas_ready;
        logic [LOST_W-1:0] lost_count;
    } result_t;

endpackage

// ----- sv/cpfm_front.sv -----
// Front end: pairs capture edges, forms the period and classifies each item.
// Depends on cpfm_pkg.
module cpfm_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpfm_pkg::sample_t              sample,
    input  logic                           accept,
    input  logic [cpfm_pkg::MOD_W-1:0]     counter_modulus,
    output logic [cpfm_pkg::CMD_W-1:0]     cmd,
    output logic [COUNT_WIDTH:0]           period
);
    import cpfm_pkg::*;

    localparam int PW = COUNT_WIDTH + 1;
    localparam int SW = (PW > MOD_W) ? PW : MOD_W;

    logic                   edge_phase_reg;
    logic                   edge_phase_next;
    logic [COUNT_WIDTH-1:0] first_count_reg;
    logic [COUNT_WIDTH-1:0] first_count_next;
    logic [COUNT_WIDTH-1:0] cap;
    logic                   wrap;
    logic [SW-1:0]          span;

    always_comb
    begin
        cap  = COUNT_WIDTH'(sample.capture_value);
        wrap = cap < first_count_reg;
        // Arithmetic is modulo the period width, as a too small modulus wraps.
        span = SW'(cap) - SW'(first_count_reg) + (wrap ? SW'(counter_modulus) : SW'(0));
        period = span[PW-1:0];

        case (sample.mode)
            MODE_CAPTURE: cmd = edge_phase_reg ? CMD_PERIOD : CMD_REPORT;
            MODE_READ:    cmd = CMD_READ;
            default:      cmd = CMD_REPORT;
        endcase

        edge_phase_next  = edge_phase_reg;
        first_count_next = first_count_reg;
        if (accept && (sample.mode == MODE_CAPTURE))
        begin
            edge_phase_next = !edge_phase_reg;
            if (!edge_phase_reg)
            begin
                first_count_next = cap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_phase_reg  <= 1'b0;
            first_count_reg <= '0;
        end
        else
        begin
            edge_phase_reg  <= edge_phase_next;
            first_count_reg <= first_count_next;
        end
    end

endmodule

// ----- sv/cpfm_queue.sv -----
// Small command queue between the front end and the back end.
// Generic storage; depends on nothing.
module cpfm_queue #(
    parameter int DATA_W = 19,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        full     = count_reg == CW'(DEPTH);
        empty    = count_reg == '0;
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/cpfm_back.sv -----
// Back end: stability test, measurement flags, bit-serial frequency divider
// and the result register. Depends on cpfm_pkg.
module cpfm_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    input  logic [cpfm_pkg::CMD_W-1:0]      cmd,
    input  logic [COUNT_WIDTH:0]            period,
    input  logic [cpfm_pkg::FREQ_W-1:0]     freq_numerator,
    input  logic [cpfm_pkg::TOL_W-1:0]      period_tolerance,
    output cpfm_pkg::result_t               result,
    output logic                            empty,
    input  logic                            pop
);
    import cpfm_pkg::*;

    localparam int PW        = COUNT_WIDTH + 1;
    localparam int DIV_STEPS = FREQ_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_DIV  = 1'b1;

    logic              state_reg,    state_next;
    logic [PW-1:0]     prev_reg,     prev_next;
    logic [FREQ_W-1:0] freq_reg,     freq_next;
    logic              stable_reg,   stable_next;
    logic              ready_reg,    ready_next;
    logic [LOST_W-1:0] lost_reg,     lost_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;
    logic [PW-1:0]     rem_reg,      rem_next;
    logic [FREQ_W-1:0] quo_reg,      quo_next;
    logic [PW-1:0]     divisor_reg,  divisor_next;
    logic [STEP_W-1:0] step_reg,     step_next;

    logic              slot_free;
    logic [PW-1:0]     diff;
    logic              in_tol;
    logic [PW:0]       shifted;
    logic [PW:0]       trial;
    logic              fits;
    logic [FREQ_W-1:0] quo_shifted;

    always_comb
    begin
        slot_free = !out_valid_reg || pop;
        cmd_pop   = (state_reg == STATE_IDLE) && cmd_valid && slot_free;
        diff      = (period >= prev_reg) ? (period - prev_reg) : (prev_reg - period);
        in_tol    = diff <= PW'(period_tolerance);

        // One quotient bit per cycle, restoring division.
        shifted     = {rem_reg, quo_reg[FREQ_W-1]};
        trial       = shifted - {1'b0, divisor_reg};
        fits        = shifted >= {1'b0, divisor_reg};
        quo_shifted = {quo_reg[FREQ_W-2:0], fits};

        state_next     = state_reg;
        prev_next      = prev_reg;
        freq_next      = freq_reg;
        stable_next    = stable_reg;
        ready_next     = ready_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;

        case (state_reg)
            STATE_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd)
                        CMD_READ:
                        begin
                            out_data_next  = '{freq_reg, stable_reg, ready_reg, lost_reg};
                            out_valid_next = 1'b1;
                            ready_next     = 1'b0;
                        end
                        CMD_PERIOD:
                        begin
                            stable_next = in_tol;
                            prev_next   = period;
                            if (ready_reg)
                            begin
                                if (lost_reg != LOST_MAX)
                                begin
                                    lost_next = lost_reg + LOST_W'(1);
                                end
                            end
                            else
                            begin
                                ready_next = 1'b1;
                                lost_next  = '0;
                            end
                            if (in_tol && (period != '0))
                            begin
                                state_next   = STATE_DIV;
                                rem_next     = '0;
                                quo_next     = freq_numerator;
                                divisor_next = period;
                                step_next    = '0;
                            end
                            else
                            begin
                                out_data_next  = '{freq_reg, in_tol, ready_next, lost_next};
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_data_next  = '{freq_reg, stable_reg, ready_reg, lost_reg};
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            STATE_DIV:
            begin
                rem_next  = fits ? trial[PW-1:0] : shifted[PW-1:0];
                quo_next  = quo_shifted;
                step_next = step_reg + STEP_W'(1);
                // The result slot was free when the division started and stays free.
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next     = STATE_IDLE;
                    freq_next      = quo_shifted;
                    out_data_next  = '{quo_shifted, stable_reg, ready_reg, lost_reg};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase

        empty  = !out_valid_reg;
        result = out_data_reg;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        divisor_reg  <= divisor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            prev_reg      <= '0;
            freq_reg      <= '0;
            stable_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            lost_reg      <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            freq_reg      <= freq_next;
            stable_reg    <= stable_next;
            ready_reg     <= ready_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

// ----- sv/capture_period_frequency_meter.sv -----
// Capture period frequency meter, top level.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on cpfm_pkg, cpfm_front, cpfm_queue and cpfm_back.
//
// Input channel: an item on sample is taken at a clock edge with push high
// and full low. Mode capture feeds edges in pairs; the closing edge of a pair
// yields a period measurement. Mode read returns the state and clears ready.
// Result channel: while empty is low the oldest result is on result and
// leaves at an edge with pop high. Every input item gives exactly one result.
// Configuration: cfg_ready is always high; cfg_index selects the modulus,
// numerator or tolerance register. Write only while the block is idle.
// Items without a division pass through the command queue into the result
// register; a stable nonzero period also runs the bit-serial divider (one
// quotient bit a cycle) before its result is registered.
// Other items go through at one per cycle while no division runs and the
// result slot is free. A four-entry command queue lets inputs keep arriving
// while the divider runs or the receiver stalls; full rises with four queued.
// Reset clears the pairing phase, flags, counters and command queue and loads the
// registers with their default values.
module capture_period_frequency_meter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  cpfm_pkg::sample_t                  sample,
    input  logic                               pop,
    output logic                               empty,
    output cpfm_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpfm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpfm_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int QDATA_W     = CMD_W + COUNT_WIDTH + 1;

    logic [MOD_W-1:0]   modulus_reg,   modulus_next;
    logic [FREQ_W-1:0]  numerator_reg, numerator_next;
    logic [TOL_W-1:0]   tolerance_reg, tolerance_next;

    logic               accept;
    logic [CMD_W-1:0]   front_cmd;
    logic [COUNT_WIDTH:0] front_period;
    logic [QDATA_W-1:0] q_pop_data;
    logic               q_empty;
    logic               q_pop;

    always_comb
    begin
        cfg_ready      = 1'b1;
        modulus_next   = modulus_reg;
        numerator_next = numerator_reg;
        tolerance_next = tolerance_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODULUS:   modulus_next   = cfg_data[MOD_W-1:0];
                CFG_NUMERATOR: numerator_next = cfg_data[FREQ_W-1:0];
                CFG_TOLERANCE: tolerance_next = cfg_data[TOL_W-1:0];
                default:       ;
            endcase
        end
        accept = push && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            numerator_reg <= NUMERATOR_RESET;
            tolerance_reg <= TOLERANCE_RESET;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            numerator_reg <= numerator_next;
            tolerance_reg <= tolerance_next;
        end
    end

    cpfm_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .accept          (accept),
        .counter_modulus (modulus_reg),
        .cmd             (front_cmd),
        .period          (front_period)
    );

    cpfm_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({front_cmd, front_period}),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    cpfm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (!q_empty),
        .cmd_pop          (q_pop),
        .cmd              (q_pop_data[QDATA_W-1 -: CMD_W]),
        .period           (q_pop_data[COUNT_WIDTH:0]),
        .freq_numerator   (numerator_reg),
        .period_tolerance (tolerance_reg),
        .result           (result),
        .empty            (empty),
        .pop              (pop)
    );

endmodule

// ----- sv/cpfm_checker.sv -----
// Port-level checks of the capture period frequency meter, bound to the top.
// Depends on cpfm_pkg and capture_period_frequency_meter_defines.svh.
`include "capture_period_frequency_meter_defines.svh"

module cpfm_props (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input cpfm_pkg::result_t result,
    input logic              cfg_ready
);
    // A waiting result stays put until it is taken.
    `CPFM_ASSERT_RST(a_result_hold, clk, rst_n,
        (!empty && !pop) |=> (!empty && $stable(result)), "result changed while stalled")

    // No result is offered while reset is applied.
    `CPFM_ASSERT_ALL(a_reset_empty, clk, !rst_n |-> empty, "result offered during reset")

    // The command queue comes out of reset with room.
    `CPFM_ASSERT_ALL(a_reset_not_full, clk,
        (rst_n && $rose(rst_n)) |-> !full, "full right after reset")

    // Configuration writes are never held off.
    `CPFM_ASSERT_RST(a_cfg_ready, clk, rst_n, cfg_ready, "configuration port not ready")

endmodule

bind capture_period_frequency_meter cpfm_props u_checker (.*);
